[rtl/core/peer_link_supervisor_macros.svh]
// Assertion helpers shared by the supervisor RTL.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef PEER_LINK_SUPERVISOR_MACROS_SVH
`define PEER_LINK_SUPERVISOR_MACROS_SVH

// ante holds, so cons must hold in the same cycle
`define PLS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never be seen
`define PLS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/core/pls_pkg.sv]
package pls_pkg;

	// field widths
	localparam int TIME_US_W = 48;
	localparam int ADDR_W    = 48;
	localparam int MS_W      = 32;
	localparam int SEQ_W     = 32;
	localparam int CNT_W     = 32;
	localparam int STR_W     = 8;
	localparam int PER_W     = 16;
	localparam int CMD_W     = 3;
	localparam int KIND_W    = 2;
	localparam int SKIND_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 48;

	localparam int US_PER_MS = 1000;
	localparam int TMO_W     = PER_W + 10;

	// divide by 1000: shift out the factor 8, then long division by 125
	// five bits a step, reciprocal multiply per step
	localparam int PRE_SHIFT   = 3;
	localparam int Y_W         = TIME_US_W - PRE_SHIFT;
	localparam int CHUNK_W     = 5;
	localparam int DIV_STEPS   = 3;
	localparam int DIV_STAGES  = 3;
	localparam int REM_W       = 7;
	localparam int V_W         = REM_W + CHUNK_W;
	localparam int RECIP_W     = 14;
	localparam int PROD_W      = V_W + RECIP_W;
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP   = 14'd8389;
	localparam logic [V_W-1:0]     DIV_LOW = 12'd125;
	localparam int QUO_W       = 39;

	localparam logic [MS_W-1:0] RTT_NONE = 32'hFFFF_FFFF;
	localparam logic [MS_W-1:0] RTT_MAX  = 32'h7FFF_FFFF;

	// register reset values
	localparam logic [PER_W-1:0] DISC_PERIOD_RST = 16'd2000;
	localparam logic [PER_W-1:0] PING_TMO_RST    = 16'd1200;
	localparam logic [PER_W-1:0] PEER_LOST_RST   = 16'd7000;
	localparam logic [PER_W-1:0] LINK_FRESH_RST  = 16'd4000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 3'd0,
		CMD_FRAME = 3'd1,
		CMD_PING  = 3'd2,
		CMD_HELLO = 3'd3,
		CMD_MODE  = 3'd4
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		FK_DISC  = 2'd0,
		FK_PING  = 2'd1,
		FK_ACK   = 2'd2,
		FK_HELLO = 2'd3
	} frame_kind_t;

	typedef enum logic [SKIND_W-1:0] {
		SK_NONE  = 3'd0,
		SK_DISC  = 3'd1,
		SK_PING  = 3'd2,
		SK_ACK   = 3'd3,
		SK_HELLO = 3'd4
	} send_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_ADDR    = 3'd0,
		CFG_DISC_PERIOD = 3'd1,
		CFG_PING_TMO    = 3'd2,
		CFG_PEER_LOST   = 3'd3,
		CFG_LINK_FRESH  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [TIME_US_W-1:0]    time_us;
		logic [ADDR_W-1:0]       source_address;
		logic [KIND_W-1:0]       frame_kind;
		logic                    frame_mode;
		logic [SEQ_W-1:0]        frame_sequence;
		logic [SEQ_W-1:0]        frame_reference;
		logic                    reported_strength_valid;
		logic signed [STR_W-1:0] reported_strength;
		logic                    strength_valid;
		logic signed [STR_W-1:0] strength;
	} item_t;

	typedef struct packed {
		logic [SKIND_W-1:0]      send_kind;
		logic [SEQ_W-1:0]        send_sequence;
		logic [SEQ_W-1:0]        send_reference;
		logic                    send_strength_valid;
		logic signed [STR_W-1:0] send_strength;
		logic                    peer_present;
		logic                    ping_waiting;
		logic                    rtt_none;
		logic                    fresh_link;
		logic [CNT_W-1:0]        acks_matched;
		logic [CNT_W-1:0]        pings_failed;
	} res_t;

endpackage

[rtl/core/pls_div1000.sv]
// Pipelined floor(num / 1000) with a side word carried alongside.
// Stage arrays are indexed by pipeline stage.
module pls_div1000 #(
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pls_pkg::TIME_US_W-1:0]  in_num,
	input  logic [SIDE_W-1:0]              in_side,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pls_pkg::QUO_W-1:0]      out_quo,
	output logic [SIDE_W-1:0]              out_side
);

	localparam int NS = pls_pkg::DIV_STAGES;

	logic                       vld_q  [NS];
	logic [pls_pkg::Y_W-1:0]    y_q    [NS];
	logic [pls_pkg::REM_W-1:0]  rem_q  [NS];
	logic [pls_pkg::Y_W-1:0]    quo_q  [NS];
	logic [SIDE_W-1:0]          side_q [NS];

	logic                       vld_w  [NS];
	logic [pls_pkg::Y_W-1:0]    y_w    [NS];
	logic [pls_pkg::REM_W-1:0]  rem_w  [NS];
	logic [pls_pkg::Y_W-1:0]    quo_w  [NS];
	logic [SIDE_W-1:0]          side_w [NS];
	logic [pls_pkg::REM_W-1:0]  rem_nx [NS];
	logic [pls_pkg::Y_W-1:0]    quo_nx [NS];
	logic                       rdy    [NS+1];

	assign rdy[NS]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];
	assign out_quo   = quo_q[NS-1][pls_pkg::QUO_W-1:0];
	assign out_side  = side_q[NS-1];

	for (genvar j = 0; j < NS; j++) begin : g_stg
		if (j == 0) begin : g_first
			assign vld_w[j]  = in_valid;
			assign y_w[j]    = in_num[pls_pkg::TIME_US_W-1:pls_pkg::PRE_SHIFT];
			assign rem_w[j]  = '0;
			assign quo_w[j]  = '0;
			assign side_w[j] = in_side;
		end else begin : g_next
			assign vld_w[j]  = vld_q[j-1];
			assign y_w[j]    = y_q[j-1];
			assign rem_w[j]  = rem_q[j-1];
			assign quo_w[j]  = quo_q[j-1];
			assign side_w[j] = side_q[j-1];
		end

		assign rdy[j] = !vld_q[j] || rdy[j+1];

		always_comb begin
			logic [pls_pkg::REM_W-1:0]   r;
			logic [pls_pkg::Y_W-1:0]     q;
			logic [pls_pkg::V_W-1:0]     v;
			logic [pls_pkg::PROD_W-1:0]  p;
			logic [pls_pkg::CHUNK_W-1:0] d;
			r = rem_w[j];
			q = quo_w[j];
			for (int c = 0; c < pls_pkg::DIV_STEPS; c++) begin
				v = {r, y_w[j][pls_pkg::Y_W-1-pls_pkg::CHUNK_W*(pls_pkg::DIV_STEPS*j+c)
					-: pls_pkg::CHUNK_W]};
				p = pls_pkg::PROD_W'(v) * pls_pkg::PROD_W'(pls_pkg::RECIP);
				d = p[pls_pkg::RECIP_SHIFT +: pls_pkg::CHUNK_W];
				r = pls_pkg::REM_W'(v - pls_pkg::V_W'(d) * pls_pkg::DIV_LOW);
				q[pls_pkg::Y_W-1-pls_pkg::CHUNK_W*(pls_pkg::DIV_STEPS*j+c)
					-: pls_pkg::CHUNK_W] = d;
			end
			rem_nx[j] = r;
			quo_nx[j] = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_q[j] <= vld_w[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && vld_w[j]) begin
				y_q[j]    <= y_w[j];
				rem_q[j]  <= rem_nx[j];
				quo_q[j]  <= quo_nx[j];
				side_q[j] <= side_w[j];
			end
		end
	end

endmodule

[rtl/core/pls_core.sv]
// Link state: one event applied per cycle unless out_ready stalls the output, result registered.
module pls_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pls_pkg::cfg_wr_t              cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pls_pkg::item_t                in_item,
	input  logic [pls_pkg::MS_W-1:0]      in_now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pls_pkg::res_t                 out_res,
	output logic [pls_pkg::TIME_US_W-1:0] out_rtt_us
);

	// registers
	logic [pls_pkg::ADDR_W-1:0]    own_addr_q;
	logic [pls_pkg::PER_W-1:0]     disc_period_q;
	logic [pls_pkg::PER_W-1:0]     ping_tmo_q;
	logic [pls_pkg::PER_W-1:0]     peer_lost_q;
	logic [pls_pkg::PER_W-1:0]     link_fresh_q;

	// link state
	logic [pls_pkg::SEQ_W-1:0]     seq_q, seq_n;
	logic                          mode_q, mode_n;
	logic                          peer_vld_q, peer_vld_n;
	logic [pls_pkg::ADDR_W-1:0]    peer_addr_q, peer_addr_n;
	logic [pls_pkg::MS_W-1:0]      disc_sent_q, disc_sent_n;
	logic [pls_pkg::MS_W-1:0]      disc_heard_q, disc_heard_n;
	logic [pls_pkg::MS_W-1:0]      traffic_q, traffic_n;
	logic                          seen_q, seen_n;
	logic [pls_pkg::MS_W-1:0]      frame_ms_q, frame_ms_n;
	logic                          pend_q, pend_n;
	logic [pls_pkg::SEQ_W-1:0]     pend_seq_q, pend_seq_n;
	logic [pls_pkg::TIME_US_W-1:0] pend_start_q, pend_start_n;
	logic                          rtt_none_q, rtt_none_n;
	logic [pls_pkg::TIME_US_W-1:0] rtt_us_q, rtt_us_n;
	logic [pls_pkg::CNT_W-1:0]     ack_cnt_q, ack_cnt_n;
	logic [pls_pkg::CNT_W-1:0]     fail_cnt_q, fail_cnt_n;

	logic                          vld_s4;
	pls_pkg::res_t                 res_s4, res_nx;
	logic [pls_pkg::TIME_US_W-1:0] rtt_us_s4;

	logic                          take;
	logic [pls_pkg::MS_W-1:0]      since_sent;
	logic [pls_pkg::TIME_US_W-1:0] since_start;
	logic [pls_pkg::TMO_W-1:0]     tmo_us;
	logic                          src_is_peer;

	function automatic logic is_stale(
		input logic [pls_pkg::MS_W-1:0]  stamp,
		input logic [pls_pkg::MS_W-1:0]  now,
		input logic [pls_pkg::PER_W-1:0] lost
	);
		logic [pls_pkg::MS_W-1:0] age;
		age = now - stamp;
		return (stamp == '0) || (age > pls_pkg::MS_W'(lost));
	endfunction

	assign in_ready    = !vld_s4 || out_ready;
	assign take        = in_valid && in_ready;
	assign since_sent  = in_now_ms - disc_sent_q;
	assign since_start = in_item.time_us - pend_start_q;
	assign tmo_us      = pls_pkg::TMO_W'(ping_tmo_q) * pls_pkg::TMO_W'(pls_pkg::US_PER_MS);
	assign src_is_peer = in_item.source_address == peer_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q    <= '0;
			disc_period_q <= pls_pkg::DISC_PERIOD_RST;
			ping_tmo_q    <= pls_pkg::PING_TMO_RST;
			peer_lost_q   <= pls_pkg::PEER_LOST_RST;
			link_fresh_q  <= pls_pkg::LINK_FRESH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pls_pkg::CFG_OWN_ADDR:    own_addr_q    <= cfg.data[pls_pkg::ADDR_W-1:0];
				pls_pkg::CFG_DISC_PERIOD: disc_period_q <= cfg.data[pls_pkg::PER_W-1:0];
				pls_pkg::CFG_PING_TMO:    ping_tmo_q    <= cfg.data[pls_pkg::PER_W-1:0];
				pls_pkg::CFG_PEER_LOST:   peer_lost_q   <= cfg.data[pls_pkg::PER_W-1:0];
				pls_pkg::CFG_LINK_FRESH:  link_fresh_q  <= cfg.data[pls_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic                           drop;
		logic [pls_pkg::SKIND_W-1:0]    snd_kind;
		logic [pls_pkg::SEQ_W-1:0]      snd_ref;
		logic                           snd_sv;
		logic signed [pls_pkg::STR_W-1:0] snd_str;
		logic                           sending;
		logic [pls_pkg::MS_W-1:0]       frame_age;
		seq_n        = seq_q;
		mode_n       = mode_q;
		peer_vld_n   = peer_vld_q;
		peer_addr_n  = peer_addr_q;
		disc_sent_n  = disc_sent_q;
		disc_heard_n = disc_heard_q;
		traffic_n    = traffic_q;
		seen_n       = seen_q;
		frame_ms_n   = frame_ms_q;
		pend_n       = pend_q;
		pend_seq_n   = pend_seq_q;
		pend_start_n = pend_start_q;
		rtt_none_n   = rtt_none_q;
		rtt_us_n     = rtt_us_q;
		ack_cnt_n    = ack_cnt_q;
		fail_cnt_n   = fail_cnt_q;
		drop         = 1'b0;
		snd_kind     = pls_pkg::SK_NONE;
		snd_ref      = '0;
		snd_sv       = 1'b0;
		snd_str      = '0;

		case (in_item.cmd)
			pls_pkg::CMD_TICK: begin
				if (since_sent >= pls_pkg::MS_W'(disc_period_q)) begin
					snd_kind    = pls_pkg::SK_DISC;
					disc_sent_n = in_now_ms;
				end
				if (peer_vld_q && is_stale(disc_heard_q, in_now_ms, peer_lost_q)
					&& is_stale(traffic_q, in_now_ms, peer_lost_q)) begin
					drop = 1'b1;
				end
				// a drop clears the pending ping before its timeout is looked at
				if (pend_q && !drop && since_start > pls_pkg::TIME_US_W'(tmo_us)) begin
					pend_n     = 1'b0;
					fail_cnt_n = fail_cnt_q + 1'b1;
				end
			end
			pls_pkg::CMD_FRAME: begin
				if (in_item.source_address != own_addr_q && in_item.frame_mode == mode_q) begin
					if (in_item.frame_kind == pls_pkg::FK_DISC) begin
						if (!peer_vld_q) begin
							peer_vld_n  = 1'b1;
							peer_addr_n = in_item.source_address;
							traffic_n   = '0;
							rtt_none_n  = 1'b1;
						end
						if (!peer_vld_q || src_is_peer) begin
							disc_heard_n = in_now_ms;
							seen_n       = 1'b1;
							frame_ms_n   = in_now_ms;
						end
					end else if (peer_vld_q && src_is_peer) begin
						traffic_n  = in_now_ms;
						seen_n     = 1'b1;
						frame_ms_n = in_now_ms;
						if (in_item.frame_kind == pls_pkg::FK_PING) begin
							snd_kind = pls_pkg::SK_ACK;
							snd_ref  = in_item.frame_sequence;
							snd_sv   = in_item.strength_valid;
							snd_str  = in_item.strength_valid ? in_item.strength : '0;
						end else if (in_item.frame_kind == pls_pkg::FK_ACK && pend_q
							&& in_item.frame_reference == pend_seq_q) begin
							pend_n    = 1'b0;
							ack_cnt_n = ack_cnt_q + 1'b1;
							if (in_item.time_us >= pend_start_q) begin
								rtt_none_n = 1'b0;
								rtt_us_n   = since_start;
							end else begin
								rtt_none_n = 1'b1;
							end
						end
					end
				end
			end
			pls_pkg::CMD_PING: begin
				if (peer_vld_q && !pend_q) begin
					snd_kind     = pls_pkg::SK_PING;
					pend_n       = 1'b1;
					pend_seq_n   = seq_q;
					pend_start_n = in_item.time_us;
				end
			end
			pls_pkg::CMD_HELLO: begin
				if (peer_vld_q) begin
					snd_kind = pls_pkg::SK_HELLO;
				end
			end
			pls_pkg::CMD_MODE: begin
				mode_n      = ~mode_q;
				drop        = 1'b1;
				snd_kind    = pls_pkg::SK_DISC;
				disc_sent_n = in_now_ms;
			end
			default: ;
		endcase

		if (drop) begin
			peer_vld_n   = 1'b0;
			peer_addr_n  = '0;
			disc_heard_n = '0;
			traffic_n    = '0;
			seen_n       = 1'b0;
			frame_ms_n   = '0;
			pend_n       = 1'b0;
			rtt_none_n   = 1'b1;
		end

		sending   = snd_kind != pls_pkg::SK_NONE;
		seq_n     = sending ? seq_q + 1'b1 : seq_q;
		frame_age = in_now_ms - frame_ms_n;

		res_nx.send_kind           = snd_kind;
		res_nx.send_sequence       = sending ? seq_q : '0;
		res_nx.send_reference      = snd_ref;
		res_nx.send_strength_valid = snd_sv;
		res_nx.send_strength       = snd_str;
		res_nx.peer_present        = peer_vld_n;
		res_nx.ping_waiting        = pend_n;
		res_nx.rtt_none            = rtt_none_n;
		res_nx.fresh_link          = peer_vld_n && seen_n
			&& (frame_age <= pls_pkg::MS_W'(link_fresh_q));
		res_nx.acks_matched        = ack_cnt_n;
		res_nx.pings_failed        = fail_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			mode_q       <= 1'b0;
			peer_vld_q   <= 1'b0;
			peer_addr_q  <= '0;
			disc_sent_q  <= '0;
			disc_heard_q <= '0;
			traffic_q    <= '0;
			seen_q       <= 1'b0;
			frame_ms_q   <= '0;
			pend_q       <= 1'b0;
			pend_seq_q   <= '0;
			pend_start_q <= '0;
			rtt_none_q   <= 1'b1;
			rtt_us_q     <= '0;
			ack_cnt_q    <= '0;
			fail_cnt_q   <= '0;
		end else if (take) begin
			seq_q        <= seq_n;
			mode_q       <= mode_n;
			peer_vld_q   <= peer_vld_n;
			peer_addr_q  <= peer_addr_n;
			disc_sent_q  <= disc_sent_n;
			disc_heard_q <= disc_heard_n;
			traffic_q    <= traffic_n;
			seen_q       <= seen_n;
			frame_ms_q   <= frame_ms_n;
			pend_q       <= pend_n;
			pend_seq_q   <= pend_seq_n;
			pend_start_q <= pend_start_n;
			rtt_none_q   <= rtt_none_n;
			rtt_us_q     <= rtt_us_n;
			ack_cnt_q    <= ack_cnt_n;
			fail_cnt_q   <= fail_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_ready) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s4    <= res_nx;
			rtt_us_s4 <= rtt_us_n;
		end
	end

	assign out_valid  = vld_s4;
	assign out_res    = res_s4;
	assign out_rtt_us = rtt_us_s4;

endmodule

[rtl/core/peer_link_supervisor.sv]
// Radio peer link supervisor. Each input word is one event (tick, received frame, ping
// request, hello request, mode toggle) and yields exactly one output word: the frame to
// send, if any, plus a status snapshot taken after the event. One word is accepted every
// cycle unless m_tready stalls the output; the result passes through three divider stages
// turning time_us into milliseconds, the registered state update, and three divider stages
// turning the stored round trip into milliseconds. The rate is set by the state update
// stage, where each event's compares and stamp updates finish in the cycle it is taken.
// Registers are written through the cfg channel, which is always ready; write only while
// no event is in flight. There is no clearing pass after reset.
`include "peer_link_supervisor_macros.svh"

module peer_link_supervisor (
	input  logic         clk,
	input  logic         arst_n,
	// config write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	// event in
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_us[47:0], source_address[95:48], frame_mode[96], frame_sequence[128:97],
	// frame_reference[160:129], reported_strength_valid[161], reported_strength[169:162],
	// strength_valid[170], strength[178:171], zero[183:179]
	input  logic [183:0] s_tdata,
	// cmd[2:0], frame_kind[4:3]
	input  logic [4:0]   s_tuser,
	// result out
	output logic         m_tvalid,
	input  logic         m_tready,
	// send_sequence[31:0], send_reference[63:32], send_strength_valid[64],
	// send_strength[72:65], peer_present[73], ping_waiting[74], round_trip_ms[106:75],
	// fresh_link[107], acks_matched[139:108], pings_failed[171:140], zero[175:172]
	output logic [175:0] m_tdata,
	// send_kind[2:0]
	output logic [2:0]   m_tuser
);

	localparam int ITEM_W = $bits(pls_pkg::item_t);
	localparam int RES_W  = $bits(pls_pkg::res_t);

	pls_pkg::cfg_wr_t            cfg_wr;
	pls_pkg::item_t              item_in, item_fr;
	logic [ITEM_W-1:0]           side_fr;
	logic                        fr_valid, fr_ready;
	logic [pls_pkg::QUO_W-1:0]   fr_quo;

	logic                        core_valid, core_ready;
	pls_pkg::res_t               core_res, res_o;
	logic [pls_pkg::TIME_US_W-1:0] core_rtt_us;
	logic [RES_W-1:0]            side_bk;
	logic [pls_pkg::QUO_W-1:0]   bk_quo;
	logic [pls_pkg::MS_W-1:0]    rtt_ms;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign item_in.cmd                     = s_tuser[2:0];
	assign item_in.frame_kind              = s_tuser[4:3];
	assign item_in.time_us                 = s_tdata[47:0];
	assign item_in.source_address          = s_tdata[95:48];
	assign item_in.frame_mode              = s_tdata[96];
	assign item_in.frame_sequence          = s_tdata[128:97];
	assign item_in.frame_reference         = s_tdata[160:129];
	assign item_in.reported_strength_valid = s_tdata[161];
	assign item_in.reported_strength       = s_tdata[169:162];
	assign item_in.strength_valid          = s_tdata[170];
	assign item_in.strength                = s_tdata[178:171];

	pls_div1000 #(
		.SIDE_W(ITEM_W)
	) u_div_now (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_num   (item_in.time_us),
		.in_side  (item_in),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_quo  (fr_quo),
		.out_side (side_fr)
	);

	assign item_fr = side_fr;

	pls_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_wr),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (item_fr),
		.in_now_ms (fr_quo[pls_pkg::MS_W-1:0]),
		.out_valid (core_valid),
		.out_ready (core_ready),
		.out_res   (core_res),
		.out_rtt_us(core_rtt_us)
	);

	pls_div1000 #(
		.SIDE_W(RES_W)
	) u_div_rtt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (core_valid),
		.in_ready (core_ready),
		.in_num   (core_rtt_us),
		.in_side  (core_res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_quo  (bk_quo),
		.out_side (side_bk)
	);

	assign res_o = side_bk;

	// saturate at the largest positive round trip; all ones when there is none
	always_comb begin
		if (res_o.rtt_none) begin
			rtt_ms = pls_pkg::RTT_NONE;
		end else if (|bk_quo[pls_pkg::QUO_W-1:pls_pkg::MS_W-1]) begin
			rtt_ms = pls_pkg::RTT_MAX;
		end else begin
			rtt_ms = {1'b0, bk_quo[pls_pkg::MS_W-2:0]};
		end
	end

	assign m_tuser = res_o.send_kind;
	assign m_tdata = {4'b0, res_o.pings_failed, res_o.acks_matched, res_o.fresh_link,
		rtt_ms, res_o.ping_waiting, res_o.peer_present, res_o.send_strength,
		res_o.send_strength_valid, res_o.send_reference, res_o.send_sequence};

	`PLS_ASSERT_IMP(a_stall_held, !s_tready, m_tvalid && !m_tready, "input stalled with no result held")
	`PLS_ASSERT_IMP(a_none_empty, m_tvalid && res_o.send_kind == pls_pkg::SK_NONE, res_o.send_sequence == '0 && res_o.send_reference == '0 && !res_o.send_strength_valid, "fields set with nothing to send")
	`PLS_ASSERT_NEVER(a_wait_peer, m_tvalid && res_o.ping_waiting && !res_o.peer_present, "ping pending without a peer")
	`PLS_ASSERT_NEVER(a_fresh_peer, m_tvalid && res_o.fresh_link && !res_o.peer_present, "fresh link without a peer")

endmodule
